>>> src/assert_macros.svh
// Assertion helpers included by the controller core.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define LVDC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Property whose consequent must hold in the cycle after the antecedent.
`define LVDC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/lvdc_pkg.sv
`default_nettype none

package lvdc_pkg;

  // Field widths.
  localparam int unsigned VOLTAGE_BITS  = 16;
  localparam int unsigned DELAY_BITS    = 24;
  localparam int unsigned BLINK_BITS    = 16;
  localparam int unsigned ALARM_BITS    = 16;
  localparam int unsigned SETTLE_BITS   = 10;
  localparam int unsigned MODE_BITS     = 3;
  localparam int unsigned APB_DATA_BITS = 32;
  localparam int unsigned APB_ADDR_BITS = 5;
  localparam int unsigned REG_IDX_BITS  = 3;

  // Operating modes, also reported as mode_code.
  localparam logic [MODE_BITS-1:0] MODE_START  = 3'd0;
  localparam logic [MODE_BITS-1:0] MODE_ARMED  = 3'd1;
  localparam logic [MODE_BITS-1:0] MODE_CUT    = 3'd2;
  localparam logic [MODE_BITS-1:0] MODE_COUNT  = 3'd3;
  localparam logic [MODE_BITS-1:0] MODE_VERIFY = 3'd4;

  // Register indexes (byte address is four times the index).
  localparam logic [REG_IDX_BITS-1:0] REG_CUTOFF = 3'd0;
  localparam logic [REG_IDX_BITS-1:0] REG_REARM  = 3'd1;
  localparam logic [REG_IDX_BITS-1:0] REG_DELAY  = 3'd2;
  localparam logic [REG_IDX_BITS-1:0] REG_BLINK  = 3'd3;
  localparam logic [REG_IDX_BITS-1:0] REG_ALARM  = 3'd4;
  localparam logic [REG_IDX_BITS-1:0] REG_SETTLE = 3'd5;

  // Register reset values.
  localparam logic [VOLTAGE_BITS-1:0] CUTOFF_RESET = 16'd11000;
  localparam logic [VOLTAGE_BITS-1:0] REARM_RESET  = 16'd12800;
  localparam logic [DELAY_BITS-1:0]   DELAY_RESET  = 24'd60000;
  localparam logic [BLINK_BITS-1:0]   BLINK_RESET  = 16'd500;
  localparam logic [ALARM_BITS-1:0]   ALARM_RESET  = 16'd5000;
  localparam logic [SETTLE_BITS-1:0]  SETTLE_RESET = 10'd100;

  typedef struct packed {
    logic [VOLTAGE_BITS-1:0] cutoff_mv;
    logic [VOLTAGE_BITS-1:0] rearm_mv;
    logic [DELAY_BITS-1:0]   delay_ms;
    logic [BLINK_BITS-1:0]   blink_ms;
    logic [ALARM_BITS-1:0]   alarm_ms;
    logic [SETTLE_BITS-1:0]  settle_ms;
  } cfg_t;

  typedef struct packed {
    logic                    sample_valid;
    logic [VOLTAGE_BITS-1:0] voltage_mv;
    logic                    test_press;
    logic                    manual_rearm;
  } item_t;

  typedef struct packed {
    logic                    relay_on;
    logic                    green_led;
    logic                    red_led;
    logic                    buzzer_on;
    logic [MODE_BITS-1:0]    mode_code;
    logic [DELAY_BITS-1:0]   remaining_ms;
    logic [VOLTAGE_BITS-1:0] held_voltage;
  } result_t;

endpackage

`default_nettype wire

>>> src/lvdc_in_if.sv
`default_nettype none

// Tick channel: one transaction per millisecond tick.
interface lvdc_in_if;
  logic                              valid;
  logic                              ready;
  logic                              sample_valid;
  logic [lvdc_pkg::VOLTAGE_BITS-1:0] voltage_mv;
  logic                              test_press;
  logic                              manual_rearm;

  modport source (
    output valid, sample_valid, voltage_mv, test_press, manual_rearm,
    input  ready
  );
  modport sink (
    input  valid, sample_valid, voltage_mv, test_press, manual_rearm,
    output ready
  );
endinterface

`default_nettype wire

>>> src/lvdc_out_if.sv
`default_nettype none

// Status channel: one transaction per processed tick.
interface lvdc_out_if;
  logic                              valid;
  logic                              ready;
  logic                              relay_on;
  logic                              green_led;
  logic                              red_led;
  logic                              buzzer_on;
  logic [lvdc_pkg::MODE_BITS-1:0]    mode_code;
  logic [lvdc_pkg::DELAY_BITS-1:0]   remaining_ms;
  logic [lvdc_pkg::VOLTAGE_BITS-1:0] held_voltage;

  modport source (
    output valid, relay_on, green_led, red_led, buzzer_on, mode_code,
           remaining_ms, held_voltage,
    input  ready
  );
  modport sink (
    input  valid, relay_on, green_led, red_led, buzzer_on, mode_code,
           remaining_ms, held_voltage,
    output ready
  );
endinterface

`default_nettype wire

>>> src/lvdc_cfg_regs.sv
`default_nettype none

// APB register file holding the thresholds and timer settings.
module lvdc_cfg_regs (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [lvdc_pkg::APB_ADDR_BITS-1:0]  paddr,
  input  wire logic [lvdc_pkg::APB_DATA_BITS-1:0]  pwdata,
  output logic      [lvdc_pkg::APB_DATA_BITS-1:0]  prdata,
  output logic                                     pready,
  output lvdc_pkg::cfg_t                           cfg_o
);

  lvdc_pkg::cfg_t                        cfg_q;
  lvdc_pkg::cfg_t                        cfg_d;
  logic [lvdc_pkg::REG_IDX_BITS-1:0]     reg_idx;
  logic                                  wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[lvdc_pkg::APB_ADDR_BITS-1:2];
  assign wr_en   = psel && penable && pwrite;

  // Write decode.
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        lvdc_pkg::REG_CUTOFF: cfg_d.cutoff_mv = pwdata[lvdc_pkg::VOLTAGE_BITS-1:0];
        lvdc_pkg::REG_REARM:  cfg_d.rearm_mv  = pwdata[lvdc_pkg::VOLTAGE_BITS-1:0];
        lvdc_pkg::REG_DELAY:  cfg_d.delay_ms  = pwdata[lvdc_pkg::DELAY_BITS-1:0];
        lvdc_pkg::REG_BLINK:  cfg_d.blink_ms  = pwdata[lvdc_pkg::BLINK_BITS-1:0];
        lvdc_pkg::REG_ALARM:  cfg_d.alarm_ms  = pwdata[lvdc_pkg::ALARM_BITS-1:0];
        lvdc_pkg::REG_SETTLE: cfg_d.settle_ms = pwdata[lvdc_pkg::SETTLE_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Read mux, zero extended to the bus width.
  always_comb begin
    unique case (reg_idx)
      lvdc_pkg::REG_CUTOFF: prdata = {{(lvdc_pkg::APB_DATA_BITS-lvdc_pkg::VOLTAGE_BITS){1'b0}},
                                      cfg_q.cutoff_mv};
      lvdc_pkg::REG_REARM:  prdata = {{(lvdc_pkg::APB_DATA_BITS-lvdc_pkg::VOLTAGE_BITS){1'b0}},
                                      cfg_q.rearm_mv};
      lvdc_pkg::REG_DELAY:  prdata = {{(lvdc_pkg::APB_DATA_BITS-lvdc_pkg::DELAY_BITS){1'b0}},
                                      cfg_q.delay_ms};
      lvdc_pkg::REG_BLINK:  prdata = {{(lvdc_pkg::APB_DATA_BITS-lvdc_pkg::BLINK_BITS){1'b0}},
                                      cfg_q.blink_ms};
      lvdc_pkg::REG_ALARM:  prdata = {{(lvdc_pkg::APB_DATA_BITS-lvdc_pkg::ALARM_BITS){1'b0}},
                                      cfg_q.alarm_ms};
      lvdc_pkg::REG_SETTLE: prdata = {{(lvdc_pkg::APB_DATA_BITS-lvdc_pkg::SETTLE_BITS){1'b0}},
                                      cfg_q.settle_ms};
      default:              prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cutoff_mv <= lvdc_pkg::CUTOFF_RESET;
      cfg_q.rearm_mv  <= lvdc_pkg::REARM_RESET;
      cfg_q.delay_ms  <= lvdc_pkg::DELAY_RESET;
      cfg_q.blink_ms  <= lvdc_pkg::BLINK_RESET;
      cfg_q.alarm_ms  <= lvdc_pkg::ALARM_RESET;
      cfg_q.settle_ms <= lvdc_pkg::SETTLE_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

>>> src/lvdc_tick.sv
`default_nettype none

// Controller state and the per-tick update. The state advances when step_i
// is high; result_o is the status after the tick being applied.
module lvdc_tick (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              step_i,
  input  wire lvdc_pkg::item_t   item_i,
  input  wire lvdc_pkg::cfg_t    cfg_i,
  output lvdc_pkg::result_t      result_o
);

  localparam logic [lvdc_pkg::DELAY_BITS-1:0] DelayMax = '1;

  logic [lvdc_pkg::MODE_BITS-1:0]    mode_q, mode_d;
  logic [lvdc_pkg::VOLTAGE_BITS-1:0] volt_q, volt_d;
  logic [lvdc_pkg::DELAY_BITS-1:0]   count_q, count_d;
  logic [lvdc_pkg::BLINK_BITS-1:0]   blink_q, blink_d;
  logic                              green_q, green_d;
  logic [lvdc_pkg::ALARM_BITS-1:0]   alarm_q, alarm_d;
  logic [lvdc_pkg::SETTLE_BITS-1:0]  settle_q, settle_d;
  logic [lvdc_pkg::DELAY_BITS-1:0]   remaining;
  logic                              buzzer;

  // Next state, applied in the same order as the tick is specified.
  always_comb begin
    mode_d    = mode_q;
    volt_d    = volt_q;
    count_d   = count_q;
    blink_d   = blink_q;
    green_d   = green_q;
    alarm_d   = alarm_q;
    settle_d  = settle_q;
    remaining = '0;

    // Sample capture; the first one picks armed or cutoff.
    if (item_i.sample_valid) begin
      volt_d = item_i.voltage_mv;
      if (mode_d == lvdc_pkg::MODE_START) begin
        if (volt_d < cfg_i.cutoff_mv) begin
          mode_d   = lvdc_pkg::MODE_CUT;
          count_d  = '0;
          settle_d = '0;
          green_d  = 1'b0;
          alarm_d  = cfg_i.alarm_ms;
        end else begin
          mode_d   = lvdc_pkg::MODE_ARMED;
          count_d  = '0;
          settle_d = '0;
          green_d  = 1'b1;
        end
      end
    end

    // Test button, then manual rearm.
    if (mode_d != lvdc_pkg::MODE_START) begin
      if (item_i.test_press) begin
        if (mode_d == lvdc_pkg::MODE_ARMED) begin
          mode_d   = lvdc_pkg::MODE_CUT;
          count_d  = '0;
          settle_d = '0;
          green_d  = 1'b0;
          alarm_d  = cfg_i.alarm_ms;
        end else if (mode_d == lvdc_pkg::MODE_CUT || mode_d == lvdc_pkg::MODE_COUNT) begin
          mode_d   = lvdc_pkg::MODE_ARMED;
          count_d  = '0;
          settle_d = '0;
          green_d  = 1'b1;
        end
      end
      if (item_i.manual_rearm) begin
        mode_d   = lvdc_pkg::MODE_ARMED;
        count_d  = '0;
        settle_d = '0;
        green_d  = 1'b1;
      end
    end

    // Mode update from the held voltage.
    unique case (mode_d)
      lvdc_pkg::MODE_ARMED: begin
        if (volt_d < cfg_i.cutoff_mv) begin
          mode_d   = lvdc_pkg::MODE_CUT;
          count_d  = '0;
          settle_d = '0;
          green_d  = 1'b0;
          alarm_d  = cfg_i.alarm_ms;
        end
      end
      lvdc_pkg::MODE_CUT: begin
        if (volt_d >= cfg_i.rearm_mv) begin
          mode_d  = lvdc_pkg::MODE_COUNT;
          count_d = '0;
          blink_d = '0;
          green_d = 1'b0;
        end
      end
      lvdc_pkg::MODE_COUNT: begin
        if (volt_d < cfg_i.rearm_mv) begin
          mode_d  = lvdc_pkg::MODE_CUT;
          count_d = '0;
        end else begin
          if (count_d != DelayMax) begin
            count_d = count_d + 1'b1;
          end
          if (count_d >= cfg_i.delay_ms) begin
            count_d  = '0;
            mode_d   = lvdc_pkg::MODE_VERIFY;
            settle_d = cfg_i.settle_ms;
          end
        end
      end
      lvdc_pkg::MODE_VERIFY: begin
        if (settle_d != '0) begin
          settle_d = settle_d - 1'b1;
        end
        if (settle_d == '0) begin
          if (volt_d >= cfg_i.cutoff_mv) begin
            mode_d   = lvdc_pkg::MODE_ARMED;
            count_d  = '0;
            settle_d = '0;
            green_d  = 1'b1;
          end else begin
            mode_d  = lvdc_pkg::MODE_CUT;
            count_d = '0;
            green_d = 1'b0;
          end
        end
      end
      default: ;
    endcase

    // Green LED and countdown display.
    if (mode_d == lvdc_pkg::MODE_ARMED) begin
      green_d = 1'b1;
    end else if (mode_d == lvdc_pkg::MODE_COUNT) begin
      blink_d = blink_d + 1'b1;
      if (blink_d >= cfg_i.blink_ms) begin
        green_d = !green_d;
        blink_d = '0;
      end
      if (cfg_i.delay_ms > count_d) begin
        remaining = cfg_i.delay_ms - count_d;
      end
    end else if (mode_d != lvdc_pkg::MODE_VERIFY) begin
      green_d = 1'b0;
    end

    // Buzzer reflects the alarm before this tick's decrement.
    buzzer = (alarm_d != '0);
    if (alarm_d != '0) begin
      alarm_d = alarm_d - 1'b1;
    end
  end

  always_comb begin
    result_o.relay_on     = (mode_d == lvdc_pkg::MODE_ARMED) ||
                            (mode_d == lvdc_pkg::MODE_VERIFY);
    result_o.green_led    = green_d;
    result_o.red_led      = (mode_d != lvdc_pkg::MODE_ARMED);
    result_o.buzzer_on    = buzzer;
    result_o.mode_code    = mode_d;
    result_o.remaining_ms = remaining;
    result_o.held_voltage = volt_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= lvdc_pkg::MODE_START;
      volt_q   <= '0;
      count_q  <= '0;
      blink_q  <= '0;
      green_q  <= 1'b0;
      alarm_q  <= '0;
      settle_q <= '0;
    end else if (step_i) begin
      mode_q   <= mode_d;
      volt_q   <= volt_d;
      count_q  <= count_d;
      blink_q  <= blink_d;
      green_q  <= green_d;
      alarm_q  <= alarm_d;
      settle_q <= settle_d;
    end
  end

endmodule

`default_nettype wire

>>> src/low_voltage_disconnect_controller_core.sv
// Battery low-voltage disconnect controller.
// tick_i carries one transaction per millisecond tick: an optional voltage
// sample with its sample_valid flag, a test button event and a manual rearm
// request. status_o returns one transaction per tick with the relay, LED and
// buzzer drives, the mode code, the countdown time left and the held voltage.
// Thresholds and timer lengths sit in an APB register file (byte address is
// four times the register index); write them only while the block is idle.
// A tick is captured in an input register and, once the status register is
// free, applied to the controller state and loaded into the status register.
// While the receiver keeps status_o.ready high, one tick per cycle is
// sustained: the input register is refilled in the same cycle that it drains.
// When the receiver holds status_o.ready low, the status register keeps its
// transaction and one further tick waits in the input register; tick_i.ready
// then drops until the status moves on.
// Reset empties both registers, restores the register defaults and puts the
// controller in the starting mode: relay open, red LED on, waiting for the
// first sample.
`include "assert_macros.svh"
`default_nettype none

module low_voltage_disconnect_controller_core (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  lvdc_in_if.sink                                  tick_i,
  lvdc_out_if.source                               status_o,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [lvdc_pkg::APB_ADDR_BITS-1:0]  paddr,
  input  wire logic [lvdc_pkg::APB_DATA_BITS-1:0]  pwdata,
  output logic      [lvdc_pkg::APB_DATA_BITS-1:0]  prdata,
  output logic                                     pready
);

  lvdc_pkg::cfg_t    cfg;
  lvdc_pkg::item_t   item_q;
  lvdc_pkg::result_t result_d;
  lvdc_pkg::result_t result_q;
  logic              item_vld_q, item_vld_d;
  logic              res_vld_q, res_vld_d;
  logic              res_free;
  logic              step;
  logic              tick_take;

  lvdc_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Handshake control for the two register stages.
  assign res_free     = !res_vld_q || status_o.ready;
  assign step         = item_vld_q && res_free;
  assign tick_i.ready = !item_vld_q || res_free;
  assign tick_take    = tick_i.valid && tick_i.ready;

  always_comb begin
    item_vld_d = item_vld_q;
    if (tick_take) begin
      item_vld_d = 1'b1;
    end else if (step) begin
      item_vld_d = 1'b0;
    end
    res_vld_d = res_vld_q;
    if (step) begin
      res_vld_d = 1'b1;
    end else if (status_o.ready) begin
      res_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
      res_vld_q  <= 1'b0;
    end else begin
      item_vld_q <= item_vld_d;
      res_vld_q  <= res_vld_d;
    end
  end

  // Input register.
  always_ff @(posedge clk_i) begin
    if (tick_take) begin
      item_q.sample_valid <= tick_i.sample_valid;
      item_q.voltage_mv   <= tick_i.voltage_mv;
      item_q.test_press   <= tick_i.test_press;
      item_q.manual_rearm <= tick_i.manual_rearm;
    end
  end

  lvdc_tick u_tick (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (item_q),
    .cfg_i    (cfg),
    .result_o (result_d)
  );

  // Status register.
  always_ff @(posedge clk_i) begin
    if (step) begin
      result_q <= result_d;
    end
  end

  assign status_o.valid        = res_vld_q;
  assign status_o.relay_on     = result_q.relay_on;
  assign status_o.green_led    = result_q.green_led;
  assign status_o.red_led      = result_q.red_led;
  assign status_o.buzzer_on    = result_q.buzzer_on;
  assign status_o.mode_code    = result_q.mode_code;
  assign status_o.remaining_ms = result_q.remaining_ms;
  assign status_o.held_voltage = result_q.held_voltage;

  // A tick applied to the state always lands in the status register.
  `LVDC_ASSERT_NEXT(a_step_loads_status, step, res_vld_q, "applied tick left no status")
  // A full input register facing a stalled status must block new ticks.
  `LVDC_ASSERT(a_stall_blocks_input, !(item_vld_q && res_vld_q && !status_o.ready) || !tick_i.ready, "tick accepted while both stages are full")
  // The countdown display is only nonzero while counting down.
  `LVDC_ASSERT(a_remaining_in_count, !res_vld_q || result_q.remaining_ms == '0 || result_q.mode_code == lvdc_pkg::MODE_COUNT, "remaining time shown outside countdown")

endmodule

`default_nettype wire
